// ===== rtl/core/swm_pkg.sv =====
// shared types and constants for the sliding window median unit
// no dependencies; imported by every module of the unit but swm_ram
package swm_pkg;

    localparam int DATA_W     = 32;
    localparam int MED_W      = 33;
    localparam int CFG_W      = 7;
    localparam int M_TDATA_W  = 40;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_EMIT
    } swm_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture a sample beat, issue ring read
        logic cfg_write; // take a new window size, empty the window
        logic remove;    // drop the leaving sample from the sorted cells
        logic insert;    // insert the new sample, write the ring
        logic load_out;  // move the median into the output register
    } swm_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;      // window holds as many samples as its size
        logic out_busy;  // output register holds a beat that is not taken
    } swm_status_t;

endpackage

// ===== rtl/core/sliding_window_median_unit.sv =====
// top level of the sliding window median unit
// depends on swm_pkg, swm_ctrl, swm_datapath
//
// channel   direction  fields
// s_*       in         tdata: sample[31:0]; tuser: start_new
// m_*       out        tdata: median_twice[32:0], zero pad [39:33]
// cfg_*     in         data: window_size[6:0]
//
// each item runs as a sequence of steps, its beat included: the beat starts the ring
// read, then a removal pass (only once the window is full) and an insertion pass
// over the sorted cells, then the median add into the registered result beat; a
// stalled output beat holds the next item in its last step.
// nothing is emitted until the window is full (window_size; zero is one; max WINDOW_MAX).
// reset clears counters and control; the sorted cells and ring are not cleared.
module sliding_window_median_unit #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [swm_pkg::DATA_W-1:0]    s_tdata,   // sample[31:0]
    input  logic                          s_tuser,   // start_new
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [swm_pkg::M_TDATA_W-1:0] m_tdata,   // median_twice[32:0], zeros above
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]     cfg_data   // window_size[6:0]
);

    import swm_pkg::*;

    swm_cmd_t         cmd;
    swm_status_t      status;
    logic [MED_W-1:0] median_twice;

    swm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    swm_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (s_tdata),
        .start_new    (s_tuser),
        .window_size  (cfg_data),
        .m_tready     (m_tready),
        .out_valid    (m_tvalid),
        .median_twice (median_twice)
    );

    assign m_tdata = {{(M_TDATA_W - MED_W){1'b0}}, median_twice};

endmodule

// ===== rtl/core/swm_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/swm_ctrl.sv =====
// controller state machine of the sliding window median unit
// depends on swm_pkg
module swm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  swm_pkg::swm_status_t status,
    output swm_pkg::swm_cmd_t    cmd
);

    import swm_pkg::*;

    swm_state_t state_reg;
    swm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // a config write takes the cycle over a sample beat
                cfg_ready = 1'b1;
                s_tready  = !cfg_valid;
                if (cfg_valid)
                begin
                    cmd.cfg_write = 1'b1;
                end
                else if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_REMOVE;
                end
            end
            ST_REMOVE:
            begin
                cmd.remove = status.full;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.full)
                begin
                    state_next = ST_IDLE;
                end
                else if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/swm_datapath.sv =====
// datapath: arrival ring ram, sorted cell row, counters and output register
// depends on swm_pkg and swm_ram
module swm_datapath #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swm_pkg::swm_cmd_t             cmd,
    output swm_pkg::swm_status_t          status,
    input  logic [swm_pkg::DATA_W-1:0]    sample,
    input  logic                          start_new,
    input  logic [swm_pkg::CFG_W-1:0]     window_size,
    input  logic                          m_tready,
    output logic                          out_valid,
    output logic [swm_pkg::MED_W-1:0]     median_twice
);

    import swm_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);

    logic [CFG_W-1:0]         window_size_reg;
    logic [CW-1:0]            fill_reg;
    logic [AW-1:0]            oldest_reg;
    logic signed [DATA_W-1:0] sample_reg;
    logic signed [DATA_W-1:0] sorted_reg [WINDOW_MAX];
    logic [MED_W-1:0]         out_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;

    logic [CW-1:0]            win;
    logic                     full;
    logic [CW-1:0]            ins_count;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] leaving;
    logic signed [DATA_W-1:0] rem_val [WINDOW_MAX];
    logic signed [DATA_W-1:0] ins_val [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]    at_or_above;
    logic [WINDOW_MAX-1:0]    not_above;
    logic [AW-1:0]            lo_idx;
    logic [AW-1:0]            hi_idx;
    logic signed [DATA_W-1:0] lo_val;
    logic signed [DATA_W-1:0] hi_val;

    // effective window: zero means one, large values saturate
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win = CW'(1);
        end
        else if (32'(window_size_reg) > 32'(WINDOW_MAX))
        begin
            win = CW'(WINDOW_MAX);
        end
        else
        begin
            win = CW'(window_size_reg);
        end
    end

    assign full      = (fill_reg == win);
    assign ins_count = full ? (win - CW'(1)) : fill_reg;
    assign rd_addr   = start_new ? '0 : oldest_reg;
    // while filling the oldest entry sits at ring index zero
    assign wr_addr   = full ? oldest_reg : fill_reg[AW-1:0];

    swm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk     (clk),
        .wr_en   (cmd.insert),
        .wr_addr (wr_addr),
        .wr_data (sample_reg),
        .rd_en   (cmd.load),
        .rd_addr (rd_addr),
        .rd_data (leaving)
    );

    // per-cell removal and insertion; the row is sorted so the flags are monotonic
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        assign at_or_above[i] = (CW'(i) < win) && (sorted_reg[i] >= leaving);
        assign not_above[i]   = (CW'(i) < ins_count) && (sorted_reg[i] <= sample_reg);

        if (i < WINDOW_MAX - 1)
        begin : g_shift_down
            assign rem_val[i] = at_or_above[i] ? sorted_reg[i+1] : sorted_reg[i];
        end
        else
        begin : g_last
            assign rem_val[i] = sorted_reg[i];
        end

        if (i == 0)
        begin : g_first
            assign ins_val[i] = not_above[i] ? sorted_reg[i] : sample_reg;
        end
        else
        begin : g_shift_up
            assign ins_val[i] = not_above[i]   ? sorted_reg[i] :
                                not_above[i-1] ? sample_reg    : sorted_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.remove)
            begin
                sorted_reg[i] <= rem_val[i];
            end
            else if (cmd.insert)
            begin
                sorted_reg[i] <= ins_val[i];
            end
        end
    end

    // median taps: both middle entries, equal for an odd window
    assign lo_idx = AW'((win - CW'(1)) >> 1);
    assign hi_idx = AW'(win >> 1);
    assign lo_val = sorted_reg[lo_idx];
    assign hi_val = sorted_reg[hi_idx];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
        end
        if (cmd.load_out)
        begin
            out_reg <= {lo_val[DATA_W-1], lo_val} + {hi_val[DATA_W-1], hi_val};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_RESET;
            fill_reg        <= '0;
            oldest_reg      <= '0;
        end
        else if (cmd.cfg_write)
        begin
            window_size_reg <= window_size;
            fill_reg        <= '0;
            oldest_reg      <= '0;
        end
        else if (cmd.load && start_new)
        begin
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else if (cmd.insert)
        begin
            if (full)
            begin
                oldest_reg <= ((CW'(oldest_reg) + CW'(1)) == win) ? '0 : oldest_reg + AW'(1);
            end
            else
            begin
                fill_reg <= fill_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.full     = full;
    assign status.out_busy = out_valid_reg && !m_tready;
    assign out_valid       = out_valid_reg;
    assign median_twice    = out_reg;

endmodule

// ===== rtl/core/swm_checker.sv =====
// port-level checks for the sliding window median unit, bound to the top level
// depends on swm_pkg
module swm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [swm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);

    import swm_pkg::*;

    // a result beat stays up until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped before it was taken");

    // one sample in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample beat taken while another is in flight");

    // a result never appears the cycle right after a sample beat
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result beat rose too soon after a sample beat");

    // config write and sample beat never share an edge
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready && s_tvalid && s_tready))
        else $error("config write and sample beat on the same edge");

    // pad bits above the median stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:MED_W] == '0))
        else $error("pad bits of the result beat are not zero");

endmodule

bind sliding_window_median_unit swm_checker u_swm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
